// ----- rtl/lstb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lstb_pkg;

  localparam int MAX_SLOTS_DEF = 16;

  localparam int CAP_W      = 5;
  localparam int POS_W      = 16;
  localparam int EXT_W      = 17;
  localparam int SLOT_IN_W  = 8;
  localparam int SLOT_OUT_W = 4;
  localparam int ACT_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [ACT_W-1:0] ACT_ADD    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_MOVE   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_GET    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_BOUNDS = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]     action;
    logic [SLOT_IN_W-1:0] slot;
    logic [POS_W-1:0]     pos_x;
    logic [POS_W-1:0]     pos_y;
    logic [POS_W-1:0]     layer_width;
    logic [POS_W-1:0]     layer_height;
  } lstb_in_t;

  typedef struct packed {
    logic                  ok;
    logic [SLOT_OUT_W-1:0] slot_out;
    logic [POS_W-1:0]      pos_x_out;
    logic [POS_W-1:0]      pos_y_out;
    logic [EXT_W-1:0]      width_out;
    logic [EXT_W-1:0]      height_out;
  } lstb_out_t;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_FLAG,
    RES_ADD,
    RES_GET,
    RES_BND
  } lstb_res_t;

  typedef struct packed {
    logic      load_in;
    logic      scan_step;
    logic      rd_en;
    logic      add_commit;
    logic      move_commit;
    logic      remove_commit;
    logic      res_load;
    lstb_res_t res_sel;
    logic      res_ok;
    logic      out_load;
  } lstb_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             live;
    logic             cnt_done;
    logic             cur_free;
    logic             out_free;
  } lstb_stat_t;

endpackage

`default_nettype wire

// ----- rtl/lstb_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lstb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lstb_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lstb_dp
  import lstb_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire lstb_in_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output lstb_out_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire lstb_cmd_t             cmd,
  output lstb_stat_t                 stat
);

  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CAP_MAX = (1 << CAP_W) - 1;
  localparam logic [CAP_W-1:0] CAP_LIM =
    CAP_W'((MAX_SLOTS > CAP_MAX) ? CAP_MAX : MAX_SLOTS);

  lstb_in_t              item_r;
  logic [CAP_W-1:0]      capacity_r;
  logic [POS_W-1:0]      base_w_r;
  logic [POS_W-1:0]      base_h_r;
  logic [MAX_SLOTS-1:0]  occ_r;
  logic [CAP_W-1:0]      cnt_r;
  logic [EXT_W-1:0]      cw_r;
  logic [EXT_W-1:0]      ch_r;
  logic                  pend_r;
  lstb_out_t             res_r;
  lstb_out_t             res_nxt;
  lstb_out_t             out_r;
  logic                  out_valid_r;

  logic [CAP_W-1:0]      eff_cap;
  logic [CAP_W-1:0]      new_eff;
  logic [SLOT_W-1:0]     slot_addr;
  logic [SLOT_W-1:0]     cnt_addr;
  logic [SLOT_W-1:0]     rd_addr;
  logic [SLOT_W-1:0]     pos_waddr;
  logic [2*POS_W-1:0]    pos_rd;
  logic [2*POS_W-1:0]    size_rd;
  logic [EXT_W-1:0]      ew;
  logic [EXT_W-1:0]      eh;
  logic                  cap_wr;

  assign eff_cap   = (capacity_r > CAP_LIM) ? CAP_LIM : capacity_r;
  assign new_eff   = (cfg_data[CAP_W-1:0] > CAP_LIM) ? CAP_LIM : cfg_data[CAP_W-1:0];
  assign cap_wr    = cfg_we && (cfg_index == REG_CAPACITY);
  assign slot_addr = SLOT_W'(item_r.slot);
  assign cnt_addr  = SLOT_W'(cnt_r);
  assign rd_addr   = (item_r.action == ACT_GET) ? slot_addr : cnt_addr;
  assign pos_waddr = cmd.add_commit ? cnt_addr : slot_addr;

  assign stat.action   = item_r.action;
  assign stat.live     = (item_r.slot < SLOT_IN_W'(eff_cap)) && occ_r[slot_addr];
  assign stat.cnt_done = (cnt_r == eff_cap);
  assign stat.cur_free = !occ_r[cnt_addr];
  assign stat.out_free = !out_valid_r || !out_stall;

  lstb_ram #(
    .WIDTH(2 * POS_W),
    .DEPTH(MAX_SLOTS)
  ) u_pos_ram (
    .clk  (clk),
    .we   (cmd.add_commit || cmd.move_commit),
    .waddr(pos_waddr),
    .wdata({item_r.pos_x, item_r.pos_y}),
    .re   (cmd.rd_en),
    .raddr(rd_addr),
    .rdata(pos_rd)
  );

  lstb_ram #(
    .WIDTH(2 * POS_W),
    .DEPTH(MAX_SLOTS)
  ) u_size_ram (
    .clk  (clk),
    .we   (cmd.add_commit),
    .waddr(cnt_addr),
    .wdata({item_r.layer_width, item_r.layer_height}),
    .re   (cmd.rd_en),
    .raddr(rd_addr),
    .rdata(size_rd)
  );

  assign ew = {1'b0, pos_rd[2*POS_W-1:POS_W]} + {1'b0, size_rd[2*POS_W-1:POS_W]};
  assign eh = {1'b0, pos_rd[POS_W-1:0]} + {1'b0, size_rd[POS_W-1:0]};

  always_comb begin
    res_nxt = '0;
    unique case (cmd.res_sel)
      RES_ZERO: begin
      end
      RES_FLAG: begin
        res_nxt.ok = cmd.res_ok;
      end
      RES_ADD: begin
        res_nxt.ok       = 1'b1;
        res_nxt.slot_out = cnt_r[SLOT_OUT_W-1:0];
      end
      RES_GET: begin
        res_nxt.ok         = 1'b1;
        res_nxt.pos_x_out  = pos_rd[2*POS_W-1:POS_W];
        res_nxt.pos_y_out  = pos_rd[POS_W-1:0];
        res_nxt.width_out  = {1'b0, size_rd[2*POS_W-1:POS_W]};
        res_nxt.height_out = {1'b0, size_rd[POS_W-1:0]};
      end
      RES_BND: begin
        res_nxt.ok         = 1'b1;
        res_nxt.width_out  = cw_r;
        res_nxt.height_out = ch_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= CAP_LIM;
      base_w_r    <= '0;
      base_h_r    <= '0;
      occ_r       <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CAPACITY:    capacity_r <= cfg_data[CAP_W-1:0];
          REG_BASE_WIDTH:  base_w_r   <= cfg_data[POS_W-1:0];
          REG_BASE_HEIGHT: base_h_r   <= cfg_data[POS_W-1:0];
          default: begin
          end
        endcase
      end
      for (int i = 0; i < MAX_SLOTS; i++) begin
        if (cap_wr && (i >= int'(new_eff))) begin
          occ_r[i] <= 1'b0;
        end
      end
      if (cmd.add_commit) begin
        occ_r[cnt_addr] <= 1'b1;
      end
      if (cmd.remove_commit) begin
        occ_r[slot_addr] <= 1'b0;
      end
      if (cmd.load_in) begin
        cnt_r <= '0;
      end else if (cmd.scan_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
      pend_r <= cmd.scan_step && cmd.rd_en && occ_r[cnt_addr];
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item_r <= in_data;
      cw_r   <= {1'b0, base_w_r};
      ch_r   <= {1'b0, base_h_r};
    end else if (pend_r) begin
      if (ew > cw_r) begin
        cw_r <= ew;
      end
      if (eh > ch_r) begin
        ch_r <= eh;
      end
    end
    if (cmd.res_load) begin
      res_r <= res_nxt;
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- rtl/lstb_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lstb_ctrl
  import lstb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire lstb_stat_t stat,
  output lstb_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ADD,
    S_GET_WAIT,
    S_BND,
    S_BND_FIN,
    S_RESP
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt    = S_RESP;
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_FLAG;
        unique case (stat.action)
          ACT_ADD: begin
            cmd.res_load = 1'b0;
            state_nxt    = S_ADD;
          end
          ACT_MOVE: begin
            cmd.move_commit = stat.live;
            cmd.res_ok      = stat.live;
          end
          ACT_REMOVE: begin
            cmd.remove_commit = stat.live;
            cmd.res_ok        = stat.live;
          end
          ACT_GET: begin
            if (stat.live) begin
              cmd.res_load = 1'b0;
              cmd.rd_en    = 1'b1;
              state_nxt    = S_GET_WAIT;
            end else begin
              cmd.res_sel = RES_ZERO;
            end
          end
          ACT_BOUNDS: begin
            cmd.res_load = 1'b0;
            state_nxt    = S_BND;
          end
          default: begin
            cmd.res_sel = RES_ZERO;
          end
        endcase
      end
      S_ADD: begin
        priority if (stat.cnt_done) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_FLAG;
          state_nxt    = S_RESP;
        end else if (stat.cur_free) begin
          cmd.add_commit = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_sel    = RES_ADD;
          state_nxt      = S_RESP;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_GET_WAIT: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_GET;
        state_nxt    = S_RESP;
      end
      S_BND: begin
        if (stat.cnt_done) begin
          state_nxt = S_BND_FIN;
        end else begin
          cmd.scan_step = 1'b1;
          cmd.rd_en     = 1'b1;
        end
      end
      S_BND_FIN: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_BND;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/layer_slot_table_with_bounds.sv -----
// Move, remove, unused codes and failed get load their result at decode; get loads it from
// the slot RAM read; add scans to the lowest free slot (or capacity when full); bounds scans
// every slot below capacity. The slot scan advances one slot a cycle. No new item is taken
// until the last result is in the output register; the next item is taken while it waits.
// Reset (rst_n, synchronous): all slots free, capacity = min(MAX_SLOTS, 31), base size 0;
// stored slot contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module layer_slot_table_with_bounds
  import lstb_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire lstb_in_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output lstb_out_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  lstb_cmd_t  cmd;
  lstb_stat_t stat;

  lstb_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  lstb_dp #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item taken but block not busy");

  a_slot_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.slot_out != '0)) |-> out_data.ok)
    else $error("slot index on a failed result");

  a_fail_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.ok) |->
      (out_data.width_out == '0 && out_data.height_out == '0 &&
       out_data.pos_x_out == '0 && out_data.pos_y_out == '0))
    else $error("failed result carries data");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import lstb_pkg::*;

  localparam int NSLOT = MAX_SLOTS_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = NSLOT + 14;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  lstb_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  lstb_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_CAPACITY;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // table state as the block should hold it
  bit occ[NSLOT];
  logic [POS_W-1:0] xs[NSLOT];
  logic [POS_W-1:0] ys[NSLOT];
  logic [POS_W-1:0] ws[NSLOT];
  logic [POS_W-1:0] hs[NSLOT];
  int used_slots = 0;
  int cap_reg = NSLOT;
  logic [POS_W-1:0] base_w = '0;
  logic [POS_W-1:0] base_h = '0;

  lstb_in_t item_backlog[$];
  lstb_out_t awaited_results[$];
  int failures = 0;
  int offered = 0;
  int results_seen = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet = 0;

  layer_slot_table_with_bounds #(.MAX_SLOTS(NSLOT)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int live_cap();
    return (cap_reg > NSLOT) ? NSLOT : cap_reg;
  endfunction

  function automatic bit slot_live(int s);
    return (s < live_cap()) && occ[s];
  endfunction

  function automatic lstb_out_t layer_table_step(lstb_in_t it);
    lstb_out_t r;
    int lim;
    int s;
    bit placed;
    logic [EXT_W-1:0] cw, ch, ew, eh;
    r = '0;
    lim = live_cap();
    s = int'(it.slot);
    placed = 1'b0;
    case (it.action)
      ACT_ADD: begin
        if (used_slots < lim) begin
          for (int i = 0; i < lim; i++) begin
            if (!placed && !occ[i]) begin
              occ[i] = 1'b1;
              xs[i] = it.pos_x;
              ys[i] = it.pos_y;
              ws[i] = it.layer_width;
              hs[i] = it.layer_height;
              used_slots++;
              r.ok = 1'b1;
              r.slot_out = SLOT_OUT_W'(i);
              placed = 1'b1;
            end
          end
        end
      end
      ACT_MOVE: begin
        if (slot_live(s)) begin
          xs[s] = it.pos_x;
          ys[s] = it.pos_y;
          r.ok = 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (slot_live(s)) begin
          occ[s] = 1'b0;
          used_slots--;
          r.ok = 1'b1;
        end
      end
      ACT_GET: begin
        if (slot_live(s)) begin
          r.ok = 1'b1;
          r.pos_x_out = xs[s];
          r.pos_y_out = ys[s];
          r.width_out = EXT_W'(ws[s]);
          r.height_out = EXT_W'(hs[s]);
        end
      end
      ACT_BOUNDS: begin
        cw = EXT_W'(base_w);
        ch = EXT_W'(base_h);
        for (int i = 0; i < lim; i++) begin
          if (occ[i]) begin
            ew = EXT_W'(xs[i]) + EXT_W'(ws[i]);
            eh = EXT_W'(ys[i]) + EXT_W'(hs[i]);
            if (ew > cw) cw = ew;
            if (eh > ch) ch = eh;
          end
        end
        r.ok = 1'b1;
        r.width_out = cw;
        r.height_out = ch;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic lstb_in_t make_item(logic [ACT_W-1:0] act, int s,
                                         logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                         logic [POS_W-1:0] w, logic [POS_W-1:0] h);
    lstb_in_t it;
    it.action = act;
    it.slot = SLOT_IN_W'(s);
    it.pos_x = x;
    it.pos_y = y;
    it.layer_width = w;
    it.layer_height = h;
    return it;
  endfunction

  function automatic logic [POS_W-1:0] rand_coord();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return POS_W'($urandom);
  endfunction

  function automatic lstb_in_t random_item();
    int r;
    logic [ACT_W-1:0] act;
    int s;
    r = $urandom_range(99);
    if (r < 35) act = ACT_ADD;
    else if (r < 50) act = ACT_MOVE;
    else if (r < 63) act = ACT_REMOVE;
    else if (r < 83) act = ACT_GET;
    else if (r < 93) act = ACT_BOUNDS;
    else act = ACT_W'($urandom_range(7, 5));
    s = ($urandom_range(3) != 0) ? $urandom_range(NSLOT - 1) : $urandom_range(255);
    return make_item(act, s, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endfunction

  task automatic check_field(input string name, input logic [EXT_W-1:0] want,
                             input logic [EXT_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    int lim;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_CAPACITY: begin
        cap_reg = int'(val[CAP_W-1:0]);
        lim = live_cap();
        used_slots = 0;
        for (int i = 0; i < NSLOT; i++) begin
          if (i >= lim) occ[i] = 1'b0;
          if (occ[i]) used_slots++;
        end
      end
      REG_BASE_WIDTH: base_w = val;
      REG_BASE_HEIGHT: base_h = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] cap, input logic [CFG_DATA_W-1:0] bw,
                            input logic [CFG_DATA_W-1:0] bh);
    write_reg(REG_CAPACITY, cap);
    write_reg(REG_BASE_WIDTH, bw);
    write_reg(REG_BASE_HEIGHT, bh);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (item_backlog.size() != 0 || in_valid || awaited_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] cap, input logic [CFG_DATA_W-1:0] bw,
                           input logic [CFG_DATA_W-1:0] bh, input int n);
    set_config(cap, bw, bh);
    repeat (n) item_backlog.push_back(random_item());
    drain();
  endtask

  // sender: prediction happens on acceptance, in issue order
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        awaited_results.push_back(layer_table_step(in_data));
      if (!in_valid || !in_stall) begin
        if (item_backlog.size() != 0 &&
            ((offered >= 260 && offered < 360) || $urandom_range(99) >= 32)) begin
          in_valid <= 1'b1;
          in_data <= item_backlog.pop_front();
          offered++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin : rx_side
    lstb_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          $error("result with no item outstanding: %h", out_data);
          failures++;
        end else begin
          want = awaited_results.pop_front();
          check_field("ok", EXT_W'(want.ok), EXT_W'(out_data.ok));
          check_field("slot_out", EXT_W'(want.slot_out), EXT_W'(out_data.slot_out));
          check_field("pos_x_out", EXT_W'(want.pos_x_out), EXT_W'(out_data.pos_x_out));
          check_field("pos_y_out", EXT_W'(want.pos_y_out), EXT_W'(out_data.pos_y_out));
          check_field("width_out", want.width_out, out_data.width_out);
          check_field("height_out", want.height_out, out_data.height_out);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (results_seen == 150 && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      out_stall <= (hold_left > 0) ||
                   (!(results_seen >= 300 && results_seen < 400) && $urandom_range(99) < 32);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, then edge values and bad slots
    item_backlog.push_back(make_item(ACT_BOUNDS, 0, 16'h0, 16'h0, 16'h0, 16'h0));
    item_backlog.push_back(make_item(ACT_GET, 0, 16'h0, 16'h0, 16'h0, 16'h0));
    item_backlog.push_back(make_item(ACT_MOVE, 0, 16'h1, 16'h1, 16'h0, 16'h0));
    item_backlog.push_back(make_item(ACT_REMOVE, 0, 16'h0, 16'h0, 16'h0, 16'h0));
    item_backlog.push_back(make_item(ACT_ADD, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    item_backlog.push_back(make_item(ACT_ADD, 255, 16'h0, 16'h0, 16'h0, 16'h0));
    item_backlog.push_back(make_item(ACT_BOUNDS, 0, 16'h0, 16'h0, 16'h0, 16'h0));
    item_backlog.push_back(make_item(ACT_GET, 0, 16'h0, 16'h0, 16'h0, 16'h0));
    item_backlog.push_back(make_item(ACT_MOVE, 1, 16'hFFFF, 16'h1234, 16'hAAAA, 16'h5555));
    item_backlog.push_back(make_item(ACT_GET, 1, 16'h0, 16'h0, 16'h0, 16'h0));
    item_backlog.push_back(make_item(ACT_GET, 255, 16'h0, 16'h0, 16'h0, 16'h0));
    item_backlog.push_back(make_item(ACT_MOVE, 16, 16'h7, 16'h7, 16'h0, 16'h0));
    item_backlog.push_back(make_item(ACT_REMOVE, 200, 16'h0, 16'h0, 16'h0, 16'h0));
    for (int a = 5; a < 8; a++)
      item_backlog.push_back(make_item(ACT_W'(a), $urandom_range(255), 16'hFFFF, 16'hFFFF,
                                       16'hFFFF, 16'hFFFF));
    item_backlog.push_back(make_item(ACT_REMOVE, 0, 16'h0, 16'h0, 16'h0, 16'h0));
    item_backlog.push_back(make_item(ACT_ADD, 0, 16'h5, 16'h6, 16'h7, 16'h8));
    item_backlog.push_back(make_item(ACT_GET, 0, 16'h0, 16'h0, 16'h0, 16'h0));
    item_backlog.push_back(make_item(ACT_REMOVE, 0, 16'h0, 16'h0, 16'h0, 16'h0));
    item_backlog.push_back(make_item(ACT_REMOVE, 0, 16'h0, 16'h0, 16'h0, 16'h0));
    drain();

    // two slots: fill, then get and bounds on the full table
    set_config(16'd2, 16'h0010, 16'hFFFF);
    item_backlog.push_back(make_item(ACT_ADD, 0, 16'h8000, 16'h0, 16'h8000, 16'h1));
    item_backlog.push_back(make_item(ACT_ADD, 0, 16'h1, 16'h1, 16'h1, 16'h1));
    item_backlog.push_back(make_item(ACT_GET, 1, 16'h0, 16'h0, 16'h0, 16'h0));
    item_backlog.push_back(make_item(ACT_BOUNDS, 0, 16'h0, 16'h0, 16'h0, 16'h0));
    drain();

    run_phase(16'd31, 16'hFFFF, 16'hFFFF, 100);
    run_phase(16'd16, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 100);
    run_phase(16'd1, 16'h0000, 16'h8000, 60);
    run_phase(16'd0, 16'd100, 16'h0000, 30);
    run_phase(16'hFFE7, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 100);
    run_phase(16'd16, 16'h0000, 16'h0000, 160);

    if (failures == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- layer_slot_table_with_bounds.f -----
rtl/lstb_pkg.sv
rtl/lstb_ram.sv
rtl/lstb_dp.sv
rtl/lstb_ctrl.sv
rtl/layer_slot_table_with_bounds.sv
tb/sv/tb_top.sv
